>>> hw/rtl/bdot_pkg.sv
// shared types and constants for the bin density overflow tracker
// no dependencies
package bdot_pkg;

   localparam int unsigned MaxBinsDefault  = 4096;
   localparam int unsigned FracBitsDefault = 8;
   localparam int unsigned PctScale        = 100;

   // register indexes on the csr port
   localparam logic [2:0] RegBinWidth     = 3'd0;
   localparam logic [2:0] RegBinHeight    = 3'd1;
   localparam logic [2:0] RegBinsAcross   = 3'd2;
   localparam logic [2:0] RegBinsDown     = 3'd3;
   localparam logic [2:0] RegTargetTop    = 3'd4;
   localparam logic [2:0] RegTargetBottom = 3'd5;

   // result status codes
   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusOutside   = 2'd1;
   localparam logic [1:0] StatusUnderflow = 2'd2;

   // command codes
   localparam logic CmdAdd    = 1'b0;
   localparam logic CmdRemove = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic        die;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [23:0] cell_area;
   } req_type;

   typedef struct packed {
      logic [11:0] bin_idx;
      logic [31:0] bin_overflow;
      logic [39:0] sum_top;
      logic [39:0] sum_bottom;
      logic [23:0] bucket_key;
      logic        heavier_die;
      logic [1:0]  status;
   } rsp_type;

   // configuration snapshot handed to the datapath
   typedef struct packed {
      logic [15:0] bin_width;
      logic [15:0] bin_height;
      logic [6:0]  bins_across;
      logic [6:0]  bins_down;
      logic [6:0]  target_top;
      logic [6:0]  target_bottom;
   } cfg_type;

endpackage

>>> hw/rtl/bdot_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on bdot_pkg
module bdot_divider
   import bdot_pkg::*;
#(
   parameter int unsigned NumWidth = 48,
   parameter int unsigned DenWidth = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumWidth-1:0] numer,
   input  logic [DenWidth-1:0] denom,
   output logic                busy,
   output logic                done,
   output logic [NumWidth-1:0] quot
);

   localparam int unsigned CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] quot_ff, quot_in;
   logic [DenWidth:0]   rem_ff, rem_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DenWidth:0]   trial;

   // shift-subtract step
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DenWidth-1:0], quot_ff[NumWidth-1]};
      if (start && !busy_ff) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

`ifndef SYNTH
   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without busy");
   a_no_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");
`endif

endmodule

>>> hw/rtl/bdot_front.sv
// front end: request queue of depth two between intake and the datapath
// depends on bdot_pkg
module bdot_front
   import bdot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    q_valid,
   output req_type q_data,
   input  logic    q_take
);

   req_type     slot_ff [2];
   logic        rd_ff, wr_ff;
   logic [1:0]  cnt_ff;
   logic        push_ok, pop_ok;

   assign req_full = (cnt_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop_ok   = q_take && q_valid;
   assign q_data   = slot_ff[rd_ff];

   // queue pointers and storage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push_ok) wr_ff <= !wr_ff;
         if (pop_ok) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
      end
      if (push_ok) slot_ff[wr_ff] <= req_data;
   end

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> rd_ff == wr_ff)
      else $error("queue pointers inconsistent");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count step");
`endif

endmodule

>>> hw/rtl/bdot_back.sv
// back end: bin lookup, area update, overflow and sums; clears its memories after reset
// depends on bdot_pkg and bdot_divider
module bdot_back
   import bdot_pkg::*;
#(
   parameter int unsigned MaxBins  = MaxBinsDefault,
   parameter int unsigned FracBits = FracBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_valid,
   input  req_type q_data,
   output logic    q_take,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   localparam int unsigned AddrWidth = (MaxBins > 1) ? $clog2(MaxBins) : 1;
   localparam int unsigned NumWidth  = 32 + 7 + FracBits;
   localparam logic [39:0] Sat40     = '1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIVX, ST_DIVY, ST_INDEX, ST_READ, ST_AREA,
      ST_SCALE, ST_DIVU, ST_OVF, ST_OUT, ST_WAIT
   } state_type;

   state_type state_ff;
   req_type   item_ff;
   logic [23:0] col_ff, row_ff;
   logic [AddrWidth-1:0] idx_ff, clr_ff;
   logic [11:0] idx_out_ff;
   logic [31:0] area_ff, old_ovf_ff, other_ovf_ff, new_ovf_ff, barea_ff;
   logic [NumWidth-1:0] num_ff;
   logic [1:0] status_ff;
   logic [39:0] sum_top_ff, sum_bottom_ff;
   rsp_type out_ff;
   logic out_valid_ff;
   logic out_load;

   // memories, area and overflow for each die
   logic [31:0] area_top_mem [MaxBins];
   logic [31:0] area_bot_mem [MaxBins];
   logic [31:0] ovf_top_mem  [MaxBins];
   logic [31:0] ovf_bot_mem  [MaxBins];
   logic [31:0] rd_area_top_ff, rd_area_bot_ff, rd_ovf_top_ff, rd_ovf_bot_ff;
   logic        mem_we;
   logic [AddrWidth-1:0] mem_addr;
   logic [31:0] wr_area, wr_ovf;

   // shared divider
   logic div_start, div_busy, div_done;
   logic [NumWidth-1:0] div_numer, div_quot;
   logic [31:0] div_denom;

   bdot_divider #(.NumWidth(NumWidth), .DenWidth(32)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_numer),
      .denom(div_denom), .busy(div_busy), .done(div_done), .quot(div_quot)
   );

   logic [15:0] bw, bh;
   assign bw = (cfg.bin_width == '0) ? 16'd1 : cfg.bin_width;
   assign bh = (cfg.bin_height == '0) ? 16'd1 : cfg.bin_height;

   // combinational helpers for the current step
   logic [30:0] row_mul;
   logic [37:0] idx_wide;
   logic        outside;
   logic [32:0] add_sum;
   logic [31:0] cur_area;
   logic [NumWidth-1:0] scaled;
   logic [NumWidth:0] tgt_full;
   logic [31:0] tgt_pct;
   logic [39:0] sum_sel, sum_sub, sum_new;
   logic [40:0] sum_add;
   logic [31:0] ovf_t, ovf_b, diff;
   logic [31:0] key_wide;

   assign row_mul  = row_ff * {24'd0, cfg.bins_across};
   assign idx_wide = {14'd0, col_ff} + {7'd0, row_mul};
   assign outside  = (col_ff >= {17'd0, cfg.bins_across}) ||
                     (row_ff >= {17'd0, cfg.bins_down}) ||
                     (idx_wide >= 38'(MaxBins));
   assign cur_area = item_ff.die ? rd_area_bot_ff : rd_area_top_ff;
   assign add_sum  = {1'b0, cur_area} + {9'd0, item_ff.cell_area};
   // scaled area numerator, area * 100 << frac, 100 = 128 - 32 + 4
   assign scaled   = NumWidth'({area_ff, 7'd0} - {2'd0, area_ff, 5'd0}
                               + {5'd0, area_ff, 2'd0}) << FracBits;
   assign tgt_pct  = {25'd0, item_ff.die ? cfg.target_bottom : cfg.target_top};
   assign tgt_full = (NumWidth + 1)'(tgt_pct) << FracBits;
   assign sum_sel  = item_ff.die ? sum_bottom_ff : sum_top_ff;
   assign sum_sub  = (sum_sel > {8'd0, old_ovf_ff}) ? sum_sel - {8'd0, old_ovf_ff} : '0;
   assign sum_add  = {1'b0, sum_sub} + {9'd0, new_ovf_ff};
   assign sum_new  = sum_add[40] ? Sat40 : sum_add[39:0];
   assign ovf_t    = item_ff.die ? other_ovf_ff : new_ovf_ff;
   assign ovf_b    = item_ff.die ? new_ovf_ff : other_ovf_ff;
   assign diff     = (ovf_t > ovf_b) ? ovf_t - ovf_b : ovf_b - ovf_t;
   assign key_wide = diff >> FracBits;

   assign q_take    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_load  = (state_ff == ST_WAIT) && (!out_valid_ff || rsp_pop);

   always_comb begin
      div_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      case (state_ff)
         ST_IDLE: begin
            div_start = q_valid;
            div_numer = NumWidth'(q_data.pos_x);
            div_denom = {16'd0, bw};
         end
         ST_DIVX: begin
            div_start = div_done;
            div_numer = NumWidth'(item_ff.pos_y);
            div_denom = {16'd0, bh};
         end
         ST_SCALE: begin
            div_start = 1'b1;
            div_numer = scaled;
            div_denom = barea_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      mem_we   = 1'b0;
      mem_addr = idx_ff;
      wr_area  = area_ff;
      wr_ovf   = new_ovf_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we   = 1'b1;
         mem_addr = clr_ff;
         wr_area  = '0;
         wr_ovf   = '0;
      end else if (state_ff == ST_OUT) begin
         mem_we = 1'b1;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (mem_we && (state_ff == ST_CLEAR || !item_ff.die)) begin
         area_top_mem[mem_addr] <= wr_area;
         ovf_top_mem[mem_addr]  <= wr_ovf;
      end
      if (mem_we && (state_ff == ST_CLEAR || item_ff.die)) begin
         area_bot_mem[mem_addr] <= wr_area;
         ovf_bot_mem[mem_addr]  <= wr_ovf;
      end
      rd_area_top_ff <= area_top_mem[mem_addr];
      rd_area_bot_ff <= area_bot_mem[mem_addr];
      rd_ovf_top_ff  <= ovf_top_mem[mem_addr];
      rd_ovf_bot_ff  <= ovf_bot_mem[mem_addr];
   end

   // sequencer and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         sum_top_ff    <= '0;
         sum_bottom_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AddrWidth'(MaxBins - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_data;
                  state_ff <= ST_DIVX;
               end
            end
            ST_DIVX: begin
               if (div_done) begin
                  col_ff   <= div_quot[23:0];
                  state_ff <= ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (div_done) begin
                  row_ff   <= div_quot[23:0];
                  state_ff <= ST_INDEX;
               end
            end
            ST_INDEX: begin
               idx_ff     <= idx_wide[AddrWidth-1:0];
               idx_out_ff <= idx_wide[11:0];
               barea_ff   <= bw * bh;
               if (outside) begin
                  status_ff <= StatusOutside;
                  state_ff  <= ST_WAIT;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_AREA;
            ST_AREA: begin
               old_ovf_ff   <= item_ff.die ? rd_ovf_bot_ff : rd_ovf_top_ff;
               other_ovf_ff <= item_ff.die ? rd_ovf_top_ff : rd_ovf_bot_ff;
               if (item_ff.cmd == CmdAdd) begin
                  area_ff   <= add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
                  status_ff <= StatusOk;
               end else if ({8'd0, item_ff.cell_area} > cur_area) begin
                  area_ff   <= '0;
                  status_ff <= StatusUnderflow;
               end else begin
                  area_ff   <= cur_area - {8'd0, item_ff.cell_area};
                  status_ff <= StatusOk;
               end
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               state_ff <= ST_DIVU;
            end
            ST_DIVU: begin
               if (div_done) begin
                  num_ff   <= div_quot;
                  state_ff <= ST_OVF;
               end
            end
            ST_OVF: begin
               if ({1'b0, num_ff} > tgt_full) begin
                  new_ovf_ff <= ((({1'b0, num_ff} - tgt_full) >> 32) != '0) ?
                                32'hFFFF_FFFF : 32'(({1'b0, num_ff} - tgt_full));
               end else begin
                  new_ovf_ff <= '0;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (item_ff.die) sum_bottom_ff <= sum_new;
               else sum_top_ff <= sum_new;
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (out_load) begin
                  out_ff.sum_top       <= sum_top_ff;
                  out_ff.sum_bottom    <= sum_bottom_ff;
                  out_ff.status        <= status_ff;
                  if (status_ff == StatusOutside) begin
                     out_ff.bin_idx      <= '0;
                     out_ff.bin_overflow <= '0;
                     out_ff.bucket_key   <= '0;
                     out_ff.heavier_die  <= 1'b0;
                  end else begin
                     out_ff.bin_idx      <= idx_out_ff;
                     out_ff.bin_overflow <= new_ovf_ff;
                     out_ff.bucket_key   <= (key_wide[31:24] != '0) ? 24'hFF_FFFF
                                            : key_wide[23:0];
                     out_ff.heavier_die  <= !(ovf_t > ovf_b);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == ST_IDLE)
      else $error("item taken while busy");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !q_take)
      else $error("item taken during clear");
   a_out_from_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_WAIT)
      else $error("result raised outside wait");
   a_take_div_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !div_busy)
      else $error("item taken while divider busy");
`endif

endmodule

>>> hw/rtl/bin_density_overflow_tracker.sv
// bin density overflow tracker: the time from request accept to result is set by
// three passes of the shared iterative divider (one quotient bit a cycle); requests
// outside the grid skip the third pass. one request in the back end at a time,
// a two-entry queue sits in front; a new request is taken only after the last result is loaded.
// synchronous reset; after reset the bin memories are cleared, and no request is taken
// meanwhile; csr writes are taken as ever.
module bin_density_overflow_tracker
   import bdot_pkg::*;
#(
   parameter int unsigned MAX_BINS  = MaxBinsDefault,
   parameter int unsigned FRAC_BITS = FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg_ff;
   logic    q_valid, q_take;
   req_type q_data;
   logic [2:0] reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[4:2];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_width     <= 16'd1;
         cfg_ff.bin_height    <= 16'd1;
         cfg_ff.bins_across   <= 7'd1;
         cfg_ff.bins_down     <= 7'd1;
         cfg_ff.target_top    <= 7'd100;
         cfg_ff.target_bottom <= 7'd100;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_sel)
            RegBinWidth:     cfg_ff.bin_width     <= csr_pwdata[15:0];
            RegBinHeight:    cfg_ff.bin_height    <= csr_pwdata[15:0];
            RegBinsAcross:   cfg_ff.bins_across   <= csr_pwdata[6:0];
            RegBinsDown:     cfg_ff.bins_down     <= csr_pwdata[6:0];
            RegTargetTop:    cfg_ff.target_top    <= csr_pwdata[6:0];
            RegTargetBottom: cfg_ff.target_bottom <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (reg_sel)
         RegBinWidth:     csr_prdata = {16'd0, cfg_ff.bin_width};
         RegBinHeight:    csr_prdata = {16'd0, cfg_ff.bin_height};
         RegBinsAcross:   csr_prdata = {25'd0, cfg_ff.bins_across};
         RegBinsDown:     csr_prdata = {25'd0, cfg_ff.bins_down};
         RegTargetTop:    csr_prdata = {25'd0, cfg_ff.target_top};
         RegTargetBottom: csr_prdata = {25'd0, cfg_ff.target_bottom};
         default:         csr_prdata = '0;
      endcase
   end

   bdot_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_data(req_data),
      .req_full(req_full), .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
   );

   bdot_back #(.MaxBins(MAX_BINS), .FracBits(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid), .q_data(q_data),
      .q_take(q_take), .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
   );

endmodule
